@@ src/lge_pkg.sv @@
// Shared types, field widths and codes for the Life generation engine.
package lge_pkg;

  localparam int CMD_W     = 2;
  localparam int POS_W     = 5;
  localparam int LEVEL_W   = 5;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int NBR_W     = 4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYERS = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  localparam int MIN_ROWS   = 3;
  localparam int MIN_COLS   = 3;
  localparam int MIN_LAYERS = 2;

  // Life rule neighbor counts
  localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef struct packed {
    logic load;        // latch accepted word
    logic cnt_clr;
    logic cnt_inc;
    logic step_run;    // issue one row read of a generation step
    logic clr_run;     // write one zero row of the clearing pass
    logic cell_wr;     // write back modified row of a cell write
    logic val_cap;     // capture cell bit of a cell read
    logic res_init;
    logic level_inc;
    logic level_zero;
    logic out_load;
  } lge_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             in_range;
    logic             step_ok;
    logic             step_last;
    logic             clr_last;
  } lge_stat_t;

endpackage

@@ src/lge_if.sv @@
// Valid/ready channel interfaces for command words and result words.
interface lge_in_if;
  import lge_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [POS_W-1:0]   row;
  logic [POS_W-1:0]   col;
  logic [POS_W-1:0]   layer;
  logic               alive;

  modport source (output valid, command, row, col, layer, alive, input ready);
  modport sink   (input valid, command, row, col, layer, alive, output ready);
endinterface

interface lge_out_if;
  import lge_pkg::*;

  logic               valid;
  logic               ready;
  logic               cell_value;
  logic [LEVEL_W-1:0] level;
  logic               finished;

  modport source (output valid, cell_value, level, finished, input ready);
  modport sink   (input valid, cell_value, level, finished, output ready);
endinterface

@@ src/lge_ctrl.sv @@
// Sequencer for cell access, generation step and clearing pass.
module lge_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lge_pkg::lge_stat_t stat,
  output lge_pkg::lge_cmd_t  cmd
);
  import lge_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_MOD   = 4'd4;
  localparam logic [3:0] S_STEP  = 4'd5;
  localparam logic [3:0] S_DRAIN = 4'd6;
  localparam logic [3:0] S_CLEAR = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_INIT: begin
        cmd.clr_run = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.res_init = 1'b1;
        cmd.cnt_clr  = 1'b1;
        unique case (stat.command) inside
          CMD_WRITE, CMD_READ: state_nxt = stat.in_range ? S_RD : S_OUT;
          CMD_STEP:            state_nxt = stat.step_ok ? S_STEP : S_OUT;
          CMD_CLEAR:           state_nxt = S_CLEAR;
        endcase
      end
      S_RD: state_nxt = S_MOD;
      S_MOD: begin
        cmd.cell_wr = (stat.command == CMD_WRITE);
        cmd.val_cap = (stat.command == CMD_READ);
        state_nxt   = S_OUT;
      end
      S_STEP: begin
        cmd.step_run = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (stat.step_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // last row lands and is written this cycle
        cmd.level_inc = 1'b1;
        state_nxt     = S_OUT;
      end
      S_CLEAR: begin
        cmd.clr_run = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.clr_last) begin
          cmd.level_zero = 1'b1;
          state_nxt      = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_DISP)
    else $error("accepted word not dispatched");

  a_drain_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |-> $past(state_r) == S_STEP)
    else $error("drain entered outside a step");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_ready) |=> state_r == S_OUT)
    else $error("result dropped while output word pending");
`endif

endmodule

@@ src/lge_dpath.sv @@
// Cell store, row window with Life rule, counters and result registers.
module lge_dpath #(
  parameter int MAX_ROWS   = 32,
  parameter int MAX_COLS   = 32,
  parameter int MAX_LAYERS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lge_pkg::lge_cmd_t                 cmd,
  output lge_pkg::lge_stat_t                stat,
  input  logic [lge_pkg::CMD_W-1:0]         in_command,
  input  logic [lge_pkg::POS_W-1:0]         in_row,
  input  logic [lge_pkg::POS_W-1:0]         in_col,
  input  logic [lge_pkg::POS_W-1:0]         in_layer,
  input  logic                              in_alive,
  input  logic                              cfg_we,
  input  logic [lge_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lge_pkg::CFG_W-1:0]         cfg_wdata,
  output logic                              out_cell_value,
  output logic [lge_pkg::LEVEL_W-1:0]       out_level,
  output logic                              out_finished
);
  import lge_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_LAYERS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int LW    = $clog2(MAX_LAYERS);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int LCW   = $clog2(MAX_LAYERS + 1);
  localparam logic [AW-1:0] ROWS_A = AW'(MAX_ROWS);
  localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

  // one word per row of one layer
  logic [MAX_COLS-1:0] mem [DEPTH];

  logic [CFG_W-1:0]    row_cfg_r, col_cfg_r, lay_cfg_r;
  logic [RCW-1:0]      rows;
  logic [CCW-1:0]      cols;
  logic [LCW-1:0]      layers;

  logic [CMD_W-1:0]    op_r;
  logic [POS_W-1:0]    row_r, col_r, layer_r;
  logic                alive_r;

  logic [LW-1:0]       level_r, level_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic                arr_v_r;
  logic [AW-1:0]       arr_k_r;

  logic [AW-1:0]       raddr_a, raddr_b, waddr, cell_addr;
  logic [MAX_COLS-1:0] rdata_a_r, rdata_b_r, wdata;
  logic                we;
  logic [RW-1:0]       step_row_a, step_row_b, arr_row;
  logic [LW-1:0]       next_layer;

  logic [MAX_COLS-1:0] up_r, mid_r;
  logic [MAX_COLS-1:0] up_l, up_rt, mid_l, mid_rt, dn_l, dn_rt;
  logic [MAX_COLS-1:0] new_row, cell_word;
  logic [NBR_W-1:0]    nbr [MAX_COLS];
  logic                arr_wr;

  logic                res_value_r, res_fin_r;

  function automatic logic [AW-1:0] row_addr(logic [LW-1:0] l, logic [RW-1:0] r);
    return AW'(l) * ROWS_A + AW'(r);
  endfunction

  // neighbor to the left, column 0 wraps to the last column in use
  function automatic logic [MAX_COLS-1:0] left_of(logic [MAX_COLS-1:0] w,
                                                  logic [CCW-1:0] n);
    logic [MAX_COLS-1:0] v;
    v    = w << 1;
    v[0] = w[CW'(n - 1'b1)];
    return v;
  endfunction

  // neighbor to the right, last column in use wraps to column 0
  function automatic logic [MAX_COLS-1:0] right_of(logic [MAX_COLS-1:0] w,
                                                   logic [CCW-1:0] n);
    logic [MAX_COLS-1:0] v;
    v = w >> 1;
    for (int j = 0; j < MAX_COLS; j++) begin
      if (j + 1 >= int'(n)) v[j] = w[0];
    end
    return v;
  endfunction

  // config counts clamped between the minimums and the store size
  always_comb begin
    if (int'(row_cfg_r) < MIN_ROWS)       rows = RCW'(MIN_ROWS);
    else if (int'(row_cfg_r) > MAX_ROWS)  rows = RCW'(MAX_ROWS);
    else                                  rows = RCW'(row_cfg_r);
    if (int'(col_cfg_r) < MIN_COLS)       cols = CCW'(MIN_COLS);
    else if (int'(col_cfg_r) > MAX_COLS)  cols = CCW'(MAX_COLS);
    else                                  cols = CCW'(col_cfg_r);
    if (int'(lay_cfg_r) < MIN_LAYERS)     layers = LCW'(MIN_LAYERS);
    else if (int'(lay_cfg_r) > MAX_LAYERS) layers = LCW'(MAX_LAYERS);
    else                                  layers = LCW'(lay_cfg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cfg_r <= CFG_RESET;
      col_cfg_r <= CFG_RESET;
      lay_cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS:   row_cfg_r <= cfg_wdata;
        CFG_COLS:   col_cfg_r <= cfg_wdata;
        CFG_LAYERS: lay_cfg_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_command;
      row_r   <= in_row;
      col_r   <= in_col;
      layer_r <= in_layer;
      alive_r <= in_alive;
    end
  end

  always_comb begin
    stat.command   = op_r;
    stat.in_range  = (int'(row_r) < int'(rows)) && (int'(col_r) < int'(cols))
                     && (int'(layer_r) < int'(layers));
    stat.step_ok   = (int'(level_r) + 1) < int'(layers);
    stat.step_last = (cnt_r == AW'(rows) + AW'(1));
    stat.clr_last  = (cnt_r == LAST_A);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr)      cnt_nxt = '0;
    else if (cmd.cnt_inc) cnt_nxt = cnt_r + 1'b1;
    level_nxt = level_r;
    if (cmd.level_zero)     level_nxt = '0;
    else if (cmd.level_inc) level_nxt = level_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      level_r <= '0;
      arr_v_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      level_r <= level_nxt;
      arr_v_r <= cmd.step_run;
    end
  end

  // step read order: last row, rows 0..last, row 0 again
  always_comb begin
    next_layer = level_r + 1'b1;
    if (cnt_r == '0)                             step_row_a = RW'(rows - 1'b1);
    else if (cnt_r == AW'(rows) + AW'(1))        step_row_a = '0;
    else                                         step_row_a = RW'(cnt_r - 1'b1);
    step_row_b = (cnt_r >= AW'(2)) ? RW'(cnt_r - AW'(2)) : '0;
    arr_row    = RW'(arr_k_r - AW'(2));
    cell_addr  = row_addr(LW'(layer_r), RW'(row_r));
    raddr_a    = cmd.step_run ? row_addr(level_r, step_row_a) : cell_addr;
    raddr_b    = row_addr(next_layer, step_row_b);
  end

  always_ff @(posedge clk) begin
    arr_k_r <= cnt_r;
    if (arr_v_r) begin
      up_r  <= mid_r;
      mid_r <= rdata_a_r;
    end
  end

  // Life rule over one row; columns beyond the count keep the old word
  always_comb begin
    up_l   = left_of(up_r, cols);
    up_rt  = right_of(up_r, cols);
    mid_l  = left_of(mid_r, cols);
    mid_rt = right_of(mid_r, cols);
    dn_l   = left_of(rdata_a_r, cols);
    dn_rt  = right_of(rdata_a_r, cols);
    for (int j = 0; j < MAX_COLS; j++) begin
      nbr[j] = NBR_W'(up_l[j]) + NBR_W'(up_r[j]) + NBR_W'(up_rt[j])
             + NBR_W'(mid_l[j]) + NBR_W'(mid_rt[j])
             + NBR_W'(dn_l[j]) + NBR_W'(rdata_a_r[j]) + NBR_W'(dn_rt[j]);
      if (j < int'(cols))
        new_row[j] = (nbr[j] == BIRTH_COUNT) || (mid_r[j] && nbr[j] == SURVIVE_COUNT);
      else
        new_row[j] = rdata_b_r[j];
    end
  end

  always_comb begin
    cell_word                 = rdata_a_r;
    cell_word[CW'(col_r)]     = alive_r;
    arr_wr                    = arr_v_r && (arr_k_r >= AW'(2));
    we    = 1'b0;
    waddr = cnt_r;
    wdata = '0;
    if (cmd.clr_run) begin
      we = 1'b1;
    end else if (cmd.cell_wr) begin
      we    = 1'b1;
      waddr = cell_addr;
      wdata = cell_word;
    end else if (arr_wr) begin
      we    = 1'b1;
      waddr = row_addr(next_layer, arr_row);
      wdata = new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (cmd.res_init) begin
      res_value_r <= 1'b0;
      res_fin_r   <= (op_r == CMD_STEP) && !stat.step_ok;
    end else if (cmd.val_cap) begin
      res_value_r <= rdata_a_r[CW'(col_r)];
    end
    if (cmd.out_load) begin
      out_cell_value <= res_value_r;
      out_level      <= LEVEL_W'(level_r);
      out_finished   <= res_fin_r;
    end
  end

`ifndef SYNTHESIS
  a_step_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    arr_wr |-> (int'(arr_k_r) - 2) < int'(rows))
    else $error("step wrote a row beyond the grid");

  a_level_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.level_inc |=> level_r == LW'($past(level_r) + 1'b1))
    else $error("level did not advance by one");

  a_step_allowed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_run |-> (int'(level_r) + 1) < int'(layers))
    else $error("step running on the last layer");
`endif

endmodule

@@ src/life_generation_engine_core.sv @@
// Top level of the Life generation engine: channels, config port, control and datapath.
// Each accepted word gives one result word; a cell write or read first reads its row,
//   while a cell outside the counts or a refused step goes straight to the result.
// Step and clear walk the store row by row; a new word waits until the result is loaded.
// Reset (rst_n low, synchronous): level 0, counts 32, then a clearing pass over all
//   MAX_ROWS * MAX_LAYERS rows with in_ready low; config writes are taken throughout.
module life_generation_engine_core #(
  parameter int MAX_ROWS   = 32,
  parameter int MAX_COLS   = 32,
  parameter int MAX_LAYERS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lge_in_if.sink                        in_ch,
  lge_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [lge_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lge_pkg::CFG_W-1:0]     cfg_wdata
);
  import lge_pkg::*;

  // controller and datapath talk only through these two groups
  lge_cmd_t  cmd;
  lge_stat_t stat;

  // controller: accepts a word only when idle; the output register lets a
  // new word in while the previous result word still waits
  lge_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: row-wide store (one word per row per layer, two read ports),
  // neighbor count over a full row per cycle, counters and result registers
  lge_dpath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_LAYERS (MAX_LAYERS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_command     (in_ch.command),
    .in_row         (in_ch.row),
    .in_col         (in_ch.col),
    .in_layer       (in_ch.layer),
    .in_alive       (in_ch.alive),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_cell_value (out_ch.cell_value),
    .out_level      (out_ch.level),
    .out_finished   (out_ch.finished)
  );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the Life generation engine: directed and random command words.
module tb_top;
  import lge_pkg::*;

  // Store sizes match the block's defaults.
  localparam int GRID_MAX    = 32;
  localparam int LAYER_MAX   = 32;
  // Slowest word is a clear over the whole store; the random mix stays far below this limit.
  localparam int CYCLE_LIMIT = 600_000;
  localparam int SETTLE_CYC  = 8;     // quiet cycles before a config write
  localparam int TAIL_CYC    = 40;    // quiet cycles after the last result
  localparam int PHASE_WORDS = 90;    // random words per config setting
  localparam int PHASES      = 10;

  // One expected result word, tagged with the command that caused it.
  typedef struct packed {
    logic               cell_value;
    logic [LEVEL_W-1:0] level;
    logic               finished;
    logic [CMD_W-1:0]   command;
  } life_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  lge_in_if  cmd_link ();
  lge_out_if res_link ();

  life_generation_engine_core #(
    .MAX_ROWS  (GRID_MAX),
    .MAX_COLS  (GRID_MAX),
    .MAX_LAYERS(LAYER_MAX)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (cmd_link),
    .out_ch   (res_link),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Golden copy of the engine: cell store indexed [layer][row][col], current
  // generation and the three count registers as written (clamped on use).
  // ---------------------------------------------------------------------------
  logic [GRID_MAX-1:0] life_cells [LAYER_MAX][GRID_MAX];
  logic [LEVEL_W-1:0]  gen_level;
  logic [CFG_W-1:0]    rows_reg;
  logic [CFG_W-1:0]    cols_reg;
  logic [CFG_W-1:0]    layers_reg;

  life_result_t awaited_words[$];
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int           stall_left     = 0;
  bit           idling         = 1'b1;   // random gaps on both channels

  // Counts below the floor act as the floor, above the store size as the size.
  function automatic int clamp_count(input logic [CFG_W-1:0] v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic int rows_in_use();
    return clamp_count(rows_reg, MIN_ROWS, GRID_MAX);
  endfunction

  function automatic int cols_in_use();
    return clamp_count(cols_reg, MIN_COLS, GRID_MAX);
  endfunction

  function automatic int layers_in_use();
    return clamp_count(layers_reg, MIN_LAYERS, LAYER_MAX);
  endfunction

  function automatic void wipe_cells();
    int l, r;
    for (l = 0; l < LAYER_MAX; l++)
      for (r = 0; r < GRID_MAX; r++)
        life_cells[l][r] = '0;
    gen_level = '0;
  endfunction

  // Applies one command to the golden state and returns the result word it makes.
  function automatic life_result_t life_outcome(input logic [CMD_W-1:0] cmd,
                                                input logic [POS_W-1:0] row,
                                                input logic [POS_W-1:0] col,
                                                input logic [POS_W-1:0] layer,
                                                input logic             alive);
    int rows, cols, layers, cur, r, c, dr, dc, n;
    bit in_grid;
    life_result_t res;
    rows    = rows_in_use();
    cols    = cols_in_use();
    layers  = layers_in_use();
    in_grid = (row < rows) && (col < cols) && (layer < layers);
    res         = '0;
    res.command = cmd;
    case (cmd)
      CMD_WRITE: begin
        if (in_grid) life_cells[layer][row][col] = alive;
      end
      CMD_READ: begin
        if (in_grid) res.cell_value = life_cells[layer][row][col];
      end
      CMD_STEP: begin
        cur = int'(gen_level);
        if (cur + 1 >= layers) begin
          res.finished = 1'b1;            // last layer in use: refused
        end else begin
          for (r = 0; r < rows; r++) begin
            for (c = 0; c < cols; c++) begin
              n = 0;
              // true torus over the rows and columns in use
              for (dr = -1; dr <= 1; dr++)
                for (dc = -1; dc <= 1; dc++)
                  if (dr != 0 || dc != 0)
                    n += life_cells[cur][(r + dr + rows) % rows][(c + dc + cols) % cols];
              if (life_cells[cur][r][c])
                life_cells[cur + 1][r][c] = (n == 2 || n == 3);
              else
                life_cells[cur + 1][r][c] = (n == 3);
            end
          end
          gen_level = LEVEL_W'(cur + 1);
        end
      end
      default: wipe_cells();
    endcase
    res.level = gen_level;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking and result-side stalls
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH @%0d: %s", cycle_count, what);
  endtask

  // rst_n, valid and ready read here are the values the edge itself sampled.
  always @(posedge clk) begin : result_check
    life_result_t want;
    if (rst_n && res_link.valid && res_link.ready) begin
      if (awaited_words.size() == 0) begin
        flag_mismatch("result word with nothing expected");
      end else begin
        want = awaited_words.pop_front();
        if (res_link.cell_value !== want.cell_value)
          flag_mismatch($sformatf("cell_value %b want %b (cmd %0d)",
                                  res_link.cell_value, want.cell_value, want.command));
        if (res_link.level !== want.level)
          flag_mismatch($sformatf("level %0d want %0d (cmd %0d)",
                                  res_link.level, want.level, want.command));
        if (res_link.finished !== want.finished)
          flag_mismatch($sformatf("finished %b want %b (cmd %0d)",
                                  res_link.finished, want.finished, want.command));
      end
    end
    // stalls come in bursts of random length
    if (stall_left > 0) begin
      stall_left--;
      res_link.ready <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      res_link.ready <= 1'b0;
    end else begin
      res_link.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  // Sends one command word; returns in the step of acceptance with valid still
  // high, so the caller either drives the next word or lowers valid right away.
  task automatic send_word(input logic [CMD_W-1:0] cmd,
                           input logic [POS_W-1:0] row,
                           input logic [POS_W-1:0] col,
                           input logic [POS_W-1:0] layer,
                           input logic             alive);
    int gap;
    life_result_t pred_word;
    if (idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      cmd_link.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_link.valid   <= 1'b1;
    cmd_link.command <= cmd;
    cmd_link.row     <= row;
    cmd_link.col     <= col;
    cmd_link.layer   <= layer;
    cmd_link.alive   <= alive;
    do @(posedge clk); while (!cmd_link.ready);
    pred_word = life_outcome(cmd, row, col, layer, alive);
    awaited_words.insert(awaited_words.size(), pred_word);
  endtask

  // Sender goes quiet until every expected word is back, then a few more cycles.
  task automatic drain_results();
    cmd_link.valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Writes all three counts on back-to-back edges while the block is idle.
  task automatic set_grid(input logic [CFG_W-1:0] rows_v,
                          input logic [CFG_W-1:0] cols_v,
                          input logic [CFG_W-1:0] layers_v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROWS;
    cfg_wdata <= rows_v;
    @(posedge clk);
    cfg_index <= CFG_COLS;
    cfg_wdata <= cols_v;
    @(posedge clk);
    cfg_index <= CFG_LAYERS;
    cfg_wdata <= layers_v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    rows_reg   = rows_v;
    cols_reg   = cols_v;
    layers_reg = layers_v;
  endtask

  // Mostly well-formed: addresses inside the grid, writes aimed at the current
  // generation so steps have live cells to work on, reads near the level.
  task automatic send_random_word();
    int rows, cols, layers, roll, top;
    logic [POS_W-1:0] r, c, l;
    logic a;
    rows   = rows_in_use();
    cols   = cols_in_use();
    layers = layers_in_use();
    roll   = $urandom_range(0, 99);
    r = POS_W'($urandom_range(0, 31));
    c = POS_W'($urandom_range(0, 31));
    l = POS_W'($urandom_range(0, 31));
    a = 1'($urandom_range(0, 1));
    if (roll < 2) begin
      send_word(CMD_CLEAR, r, c, l, a);
    end else if (roll < 24) begin
      send_word(CMD_STEP, r, c, l, a);
    end else if (roll < 62) begin
      if ($urandom_range(0, 9) != 0) begin
        r = POS_W'($urandom_range(0, rows - 1));
        c = POS_W'($urandom_range(0, cols - 1));
        l = ($urandom_range(0, 2) != 0) ? gen_level
                                        : POS_W'($urandom_range(0, layers - 1));
        a = ($urandom_range(0, 2) != 0);
      end
      send_word(CMD_WRITE, r, c, l, a);
    end else begin
      if ($urandom_range(0, 9) != 0) begin
        top = (int'(gen_level) + 1 < layers) ? int'(gen_level) + 1 : layers - 1;
        r = POS_W'($urandom_range(0, rows - 1));
        c = POS_W'($urandom_range(0, cols - 1));
        l = POS_W'($urandom_range(0, top));
      end
      send_word(CMD_READ, r, c, l, a);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh store reads dead, including a layer far above the level.
  task automatic test_reset_state();
    send_word(CMD_READ, 5'd0, 5'd0, 5'd0, 1'b0);
    send_word(CMD_READ, 5'd31, 5'd31, 5'd31, 1'b1);
  endtask

  // Extreme addresses on the full 32x32x32 store.
  task automatic test_corner_cells();
    send_word(CMD_WRITE, 5'd0, 5'd0, 5'd0, 1'b1);
    send_word(CMD_WRITE, 5'd31, 5'd31, 5'd31, 1'b1);
    send_word(CMD_READ, 5'd31, 5'd31, 5'd31, 1'b0);
    send_word(CMD_READ, 5'd0, 5'd0, 5'd0, 1'b0);
    send_word(CMD_WRITE, 5'd0, 5'd0, 5'd0, 1'b0);
  endtask

  // Blinker across the column seam and the row seam: checks true wraparound.
  task automatic test_torus_step();
    send_word(CMD_WRITE, 5'd0, 5'd31, 5'd0, 1'b1);
    send_word(CMD_WRITE, 5'd0, 5'd0, 5'd0, 1'b1);
    send_word(CMD_WRITE, 5'd0, 5'd1, 5'd0, 1'b1);
    send_word(CMD_STEP, 5'd0, 5'd0, 5'd0, 1'b0);
    send_word(CMD_READ, 5'd31, 5'd0, 5'd1, 1'b0);
    send_word(CMD_READ, 5'd1, 5'd0, 5'd1, 1'b0);
    send_word(CMD_READ, 5'd0, 5'd31, 5'd1, 1'b0);
  endtask

  // Counts out of range (rows low, cols high, layers low): out-of-grid write
  // and read, step refused on the last layer, clear, one step, then refusal again.
  task automatic test_small_grid();
    set_grid(6'd2, 6'd63, 6'd1);
    send_word(CMD_WRITE, 5'd5, 5'd3, 5'd0, 1'b1);
    send_word(CMD_READ, 5'd5, 5'd3, 5'd0, 1'b0);
    send_word(CMD_READ, 5'd1, 5'd0, 5'd1, 1'b0);
    send_word(CMD_READ, 5'd0, 5'd0, 5'd2, 1'b0);
    send_word(CMD_STEP, 5'd0, 5'd0, 5'd0, 1'b0);
    send_word(CMD_CLEAR, 5'd31, 5'd31, 5'd31, 1'b1);
    send_word(CMD_STEP, 5'd0, 5'd0, 5'd0, 1'b0);
    send_word(CMD_STEP, 5'd0, 5'd0, 5'd0, 1'b0);
    send_word(CMD_WRITE, 5'd2, 5'd31, 5'd1, 1'b0);
    send_word(CMD_READ, 5'd2, 5'd31, 5'd1, 1'b0);
  endtask

  // Random words under a series of count settings; the last phase runs with
  // no gaps at all, and now and then the sender waits for a full drain.
  task automatic test_random_traffic();
    int p, k;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_grid(6'd32, 6'd32, 6'd32);
        1:       set_grid(6'd5, 6'd4, 6'd3);
        2:       set_grid(6'd0, 6'd1, 6'd0);
        3:       set_grid(6'd63, 6'd7, 6'd63);
        4:       set_grid(6'd3, 6'd33, 6'd2);
        5:       set_grid(6'd8, 6'd8, 6'd12);
        default: set_grid(CFG_W'(($urandom_range(0, 1) != 0) ? $urandom_range(3, 9)
                                                              : $urandom_range(0, 63)),
                          CFG_W'(($urandom_range(0, 1) != 0) ? $urandom_range(3, 9)
                                                              : $urandom_range(0, 63)),
                          CFG_W'($urandom_range(0, 63)));
      endcase
      idling = (p != PHASES - 1);
      for (k = 0; k < PHASE_WORDS; k++) begin
        if (p != PHASES - 1 && $urandom_range(0, 39) == 0) idling = !idling;
        if (p != PHASES - 1 && $urandom_range(0, 119) == 0) drain_results();
        send_random_word();
      end
    end
  endtask

  initial begin
    cmd_link.valid   = 1'b0;
    cmd_link.command = CMD_READ;
    cmd_link.row     = '0;
    cmd_link.col     = '0;
    cmd_link.layer   = '0;
    cmd_link.alive   = 1'b0;
    res_link.ready   = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_ROWS;
    cfg_wdata        = CFG_RESET;
    rst_n            = 1'b0;
    rows_reg         = CFG_RESET;
    cols_reg         = CFG_RESET;
    layers_reg       = CFG_RESET;
    wipe_cells();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // the clearing pass after reset holds in_ready low; send_word waits it out

    test_reset_state();
    test_corner_cells();
    test_torus_step();
    test_small_grid();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYC) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
